>>> hdl/gdad_pkg.sv
// Shared types, constants and calendar helpers for the date-plus-days block.
// No dependencies; imported by gdad_ctrl, gdad_datapath and the top level.
package gdad_pkg;

  localparam int unsigned CYCLE_DAYS  = 146097;  // days in 400 Gregorian years
  localparam int unsigned CYCLE_YEARS = 400;
  localparam int unsigned REM_W       = 18;      // holds a remainder below CYCLE_DAYS
  localparam int unsigned Y400_W      = 9;       // holds year mod 400
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned STEP_W      = 6;       // days consumed by one month step

  // reciprocal divide: q ~= (x * floor(2^32 / d)) >> 32, low by at most one
  localparam int unsigned DIV_X_W     = 32;        // dividends widened to this
  localparam int unsigned DAYS_RECIP  = 29398;     // floor(2^32 / 146097)
  localparam int unsigned YEARS_RECIP = 10737418;  // floor(2^32 / 400)
  localparam int unsigned DQ_W        = 15;        // days / 146097 for a 32-bit count
  localparam int unsigned YQ_W        = 24;        // year / 400 for a 32-bit year
  localparam int unsigned DIV_STEPS   = 4;         // multiply, back-multiply, subtract, fix

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_MAX = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVMOD,
    ST_CHECK,
    ST_CYCLE,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;         // take the input beat
    logic divmod_step;  // one stage of days/146097 and year mod 400
    logic check;        // validate date, form cycles*400
    logic cycle_add;    // add whole 400-year cycles
    logic walk_step;    // advance by one month
    logic capture;      // load the result register
  } cmd_t;

  typedef struct packed {
    logic step_last;    // final divide/modulo stage this cycle
    logic invalid;      // starting date out of range
    logic walk_end;     // month walk finishes this cycle
    logic out_free;     // result register can take a new result
  } status_t;

  function automatic logic is_leap(input logic [Y400_W-1:0] y400);
    logic by100;
    by100 = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
    return ((y400[1:0] == 2'b00) && !by100) || (y400 == '0);
  endfunction

  // Month length; zero for a month code outside the calendar.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MON_FEB:                                    len = leap ? 5'd29 : 5'd28;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

endpackage

>>> hdl/gdad_ctrl.sv
// Sequencer for the date-plus-days block: divide, check, cycle add, month walk.
// Depends on gdad_pkg; drives gdad_datapath through cmd_t / status_t.
module gdad_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  gdad_pkg::status_t  status,
  output gdad_pkg::cmd_t     cmd
);
  import gdad_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_DIVMOD;
      ST_DIVMOD: if (status.step_last) state_next = ST_CHECK;
      ST_CHECK:  state_next = status.invalid ? ST_FIN : ST_CYCLE;
      ST_CYCLE:  state_next = ST_WALK;
      ST_WALK:   if (status.walk_end) state_next = ST_FIN;
      ST_FIN:    if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DIVMOD: cmd.divmod_step = 1'b1;
      ST_CHECK:  cmd.check       = 1'b1;
      ST_CYCLE:  cmd.cycle_add   = 1'b1;
      ST_WALK:   cmd.walk_step   = 1'b1;
      ST_FIN:    cmd.capture     = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

>>> hdl/gdad_datapath.sv
// Datapath: reciprocal divide by 146097 and mod 400, cycle add, month walk,
// result register. Depends on gdad_pkg; sequenced by gdad_ctrl.
module gdad_datapath #(
  parameter int YEAR_BITS = 16,
  parameter int DAYS_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  gdad_pkg::cmd_t                     cmd,
  output gdad_pkg::status_t                  status,
  input  logic [gdad_pkg::DAY_W-1:0]         start_day,
  input  logic [gdad_pkg::MONTH_W-1:0]       start_month,
  input  logic [YEAR_BITS-1:0]               start_year,
  input  logic [DAYS_BITS-1:0]               add_days,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [gdad_pkg::DAY_W-1:0]         end_day,
  output logic [gdad_pkg::MONTH_W-1:0]       end_month,
  output logic [YEAR_BITS-1:0]               end_year,
  output logic                               invalid_date,
  output logic                               year_overflow
);
  import gdad_pkg::*;

  localparam int PROD_W  = DQ_W + Y400_W;
  localparam int CMP_W   = (PROD_W > YEAR_BITS) ? PROD_W : YEAR_BITS;
  localparam int SUM_W   = ((DAYS_BITS > DAY_W) ? DAYS_BITS : DAY_W) + 1;
  localparam int REMX_W  = (DAYS_BITS > REM_W) ? DAYS_BITS : REM_W;
  localparam int DMUL_W  = DIV_X_W + DQ_W;
  localparam int YMUL_W  = DIV_X_W + YQ_W;
  localparam int DBCK_W  = DQ_W + REM_W;
  localparam int YBCK_W  = YQ_W + Y400_W;
  localparam logic [YEAR_BITS-1:0] YMAX = {YEAR_BITS{1'b1}};

  logic [DAY_W-1:0]     day;
  logic [MONTH_W-1:0]   month;
  logic [YEAR_BITS-1:0] year;
  logic [DAYS_BITS-1:0] days;
  logic [DQ_W-1:0]      quot;
  logic [REM_W-1:0]     rem;
  logic [Y400_W-1:0]    y400;
  logic [DIV_STEPS-1:0] phase;
  logic [DMUL_W-1:0]    dmul;
  logic [YMUL_W-1:0]    ymul;
  logic [DIV_X_W-1:0]   dback;
  logic [DIV_X_W-1:0]   yback;
  logic [REM_W:0]       d_t;
  logic [Y400_W:0]      y_t;
  logic [PROD_W-1:0]    prod;
  logic                 invalid;
  logic                 ovf;

  logic                 leap;
  logic [DAY_W-1:0]     len;
  logic [DIV_X_W-1:0]   dx;
  logic [DIV_X_W-1:0]   yx;
  logic [DQ_W-1:0]      dq_est;
  logic [YQ_W-1:0]      yq_est;
  logic [DBCK_W-1:0]    dback_full;
  logic [YBCK_W-1:0]    yback_full;
  logic [DIV_X_W-1:0]   d_sub;
  logic [DIV_X_W-1:0]   y_sub;
  logic [REM_W:0]       d_nx;
  logic                 d_ge;
  logic [Y400_W:0]      y_nx;
  logic                 y_ge;
  logic                 valid_in;
  logic [PROD_W-1:0]    prod_next;
  logic [CMP_W-1:0]     headroom;
  logic                 cyc_ovf;
  logic [SUM_W-1:0]     sum;
  logic                 fits;
  logic [STEP_W-1:0]    step;
  logic [SUM_W-1:0]     days_less;
  logic [REMX_W-1:0]    rem_ext;
  logic                 wrap;
  logic                 year_top;
  logic                 walk_end;

  always_comb begin
    leap     = is_leap(y400);
    len      = month_len(month, leap);

    // estimate quotients by reciprocal, subtract back, then one correction
    dx         = DIV_X_W'(days);
    yx         = DIV_X_W'(year);
    dq_est     = dmul[DMUL_W-1:DIV_X_W];
    yq_est     = ymul[YMUL_W-1:DIV_X_W];
    dback_full = DBCK_W'(dq_est) * DBCK_W'(CYCLE_DAYS);
    yback_full = YBCK_W'(yq_est) * YBCK_W'(CYCLE_YEARS);
    d_sub      = dx - dback;
    y_sub      = yx - yback;
    d_ge       = d_t >= (REM_W+1)'(CYCLE_DAYS);
    d_nx       = d_ge ? d_t - (REM_W+1)'(CYCLE_DAYS) : d_t;
    y_ge       = y_t >= (Y400_W+1)'(CYCLE_YEARS);
    y_nx       = y_ge ? y_t - (Y400_W+1)'(CYCLE_YEARS) : y_t;

    valid_in = (day != '0) && (day <= len);

    // quot * 400 = quot*256 + quot*128 + quot*16
    prod_next = (PROD_W'(quot) << 8) + (PROD_W'(quot) << 7) + (PROD_W'(quot) << 4);
    headroom  = CMP_W'(YMAX - year);
    cyc_ovf   = CMP_W'(prod) > headroom;

    sum       = SUM_W'(days) + SUM_W'(day);
    fits      = sum <= SUM_W'(len);
    step      = STEP_W'(len) - STEP_W'(day) + STEP_W'(1);
    days_less = SUM_W'(days) - SUM_W'(step);
    rem_ext   = REMX_W'(rem);

    wrap      = month == MON_DEC;
    year_top  = year == YMAX;
    walk_end  = ovf || (days == '0) || fits || (wrap && year_top);
  end

  assign status.step_last = phase[DIV_STEPS-1];
  assign status.invalid   = !valid_in;
  assign status.walk_end  = walk_end;
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day     <= start_day;
      month   <= start_month;
      year    <= start_year;
      days    <= add_days;
      phase   <= DIV_STEPS'(1);
      invalid <= 1'b0;
      ovf     <= 1'b0;
    end
    if (cmd.divmod_step) begin
      phase <= phase << 1;
      if (phase[0]) begin
        dmul <= DMUL_W'(dx) * DMUL_W'(DAYS_RECIP);
        ymul <= YMUL_W'(yx) * YMUL_W'(YEARS_RECIP);
      end
      if (phase[1]) begin
        quot  <= dq_est;
        dback <= dback_full[DIV_X_W-1:0];
        yback <= yback_full[DIV_X_W-1:0];
      end
      if (phase[2]) begin
        d_t <= d_sub[REM_W:0];
        y_t <= y_sub[Y400_W:0];
      end
      if (phase[3]) begin
        rem  <= d_nx[REM_W-1:0];
        quot <= quot + DQ_W'(d_ge);
        y400 <= y_nx[Y400_W-1:0];
      end
    end
    if (cmd.check) begin
      invalid <= !valid_in;
      prod    <= prod_next;
      days    <= rem_ext[DAYS_BITS-1:0];
    end
    if (cmd.cycle_add) begin
      if (cyc_ovf) begin
        ovf <= 1'b1;
      end else begin
        year <= YEAR_BITS'(CMP_W'(year) + CMP_W'(prod));
      end
    end
    if (cmd.walk_step && !ovf && (days != '0)) begin
      if (fits) begin
        day  <= sum[DAY_W-1:0];
        days <= '0;
      end else begin
        days <= days_less[DAYS_BITS-1:0];
        day  <= DAY_W'(1);
        if (wrap) begin
          month <= MON_JAN;
          if (year_top) begin
            ovf <= 1'b1;
          end else begin
            year <= year + YEAR_BITS'(1);
            y400 <= (y400 == Y400_W'(CYCLE_YEARS - 1)) ? '0 : y400 + Y400_W'(1);
          end
        end else begin
          month <= month + MONTH_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      invalid_date  <= invalid;
      year_overflow <= ovf;
      end_day       <= ovf ? DAY_MAX : day;
      end_month     <= ovf ? MON_DEC : month;
      end_year      <= ovf ? YMAX : year;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.capture) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

>>> hdl/gregorian_date_add_days.sv
// Gregorian date plus days: one result beat per input beat.
// Sequence from the accepting edge: reciprocal divide/modulo (multiply, back-multiply,
// subtract, fix), date check, 400-year add, month walk, then capture once the result
// register is free; an invalid date skips the add and the walk.
// One item in flight; a new beat is taken the cycle after the previous result is latched.
// Reset (rst, synchronous, active high) empties the sequencer and the output.
module gregorian_date_add_days #(
  parameter int YEAR_BITS = 16,
  parameter int DAYS_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata, LSB up: start_day[5], start_month[4], start_year[YEAR_BITS],
  // add_days[DAYS_BITS], zero pad to bytes
  input  logic [((9 + YEAR_BITS + DAYS_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata, LSB up: end_day[5], end_month[4], end_year[YEAR_BITS],
  // invalid_date[1], year_overflow[1], zero pad to bytes
  output logic [((11 + YEAR_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
  import gdad_pkg::*;

  localparam int OUT_W = ((11 + YEAR_BITS + 7) / 8) * 8;
  localparam int Y_LO  = DAY_W + MONTH_W;
  localparam int D_LO  = Y_LO + YEAR_BITS;

  cmd_t    cmd;
  status_t status;

  logic [DAY_W-1:0]     start_day;
  logic [MONTH_W-1:0]   start_month;
  logic [YEAR_BITS-1:0] start_year;
  logic [DAYS_BITS-1:0] add_days;
  logic [DAY_W-1:0]     end_day;
  logic [MONTH_W-1:0]   end_month;
  logic [YEAR_BITS-1:0] end_year;
  logic                 invalid_date;
  logic                 year_overflow;

  // unpack the input beat
  assign start_day   = s_tdata[DAY_W-1:0];
  assign start_month = s_tdata[Y_LO-1:DAY_W];
  assign start_year  = s_tdata[D_LO-1:Y_LO];
  assign add_days    = s_tdata[D_LO+DAYS_BITS-1:D_LO];

  // pack the result beat, pad bits zero
  assign m_tdata = OUT_W'({year_overflow, invalid_date, end_year, end_month, end_day});

  gdad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gdad_datapath #(
    .YEAR_BITS (YEAR_BITS),
    .DAYS_BITS (DAYS_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .add_days      (add_days),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .end_day       (end_day),
    .end_month     (end_month),
    .end_year      (end_year),
    .invalid_date  (invalid_date),
    .year_overflow (year_overflow)
  );

  // an invalid start date never reaches the add, so cannot overflow
  a_flags_exclusive : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(invalid_date && year_overflow))
    else $error("invalid_date and year_overflow both set");

  // overflow saturates to the last day of the largest year
  a_saturate : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && year_overflow) |->
      (end_day == DAY_MAX) && (end_month == MON_DEC) && (&end_year))
    else $error("overflow result not saturated");

  // a valid start date always gives a real calendar month and day
  a_valid_result : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !invalid_date) |->
      (end_month >= MON_JAN) && (end_month <= MON_DEC) && (end_day != '0))
    else $error("result date out of calendar range");

  // one item in flight: the input closes straight after a beat is taken
  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

endmodule
